### design/crc_pkg.sv
// Shared types and constants for the circle raster canvas.
`default_nettype none

package crc_pkg;

    localparam int MAX_SIDE_DEF  = 256;
    localparam int FRAC_BITS_DEF = 8;
    localparam int FIELD_W       = 20;
    localparam int CHAR_W        = 8;
    localparam int POS_IN_W      = 8;
    localparam int SQ_W          = 2 * FIELD_W;
    localparam int QUEUE_DEPTH   = 2;
    localparam int APB_ADDR_W    = 4;
    localparam int APB_DATA_W    = 32;
    localparam int SIDE_RESET    = 256;
    localparam logic [CHAR_W-1:0] BG_RESET = 8'd32;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_OUTLINE = 2'd1,
        OP_FILLED  = 2'd2,
        OP_READ    = 2'd3
    } crc_op_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_REFUSED = 2'd1,
        STATUS_OUTSIDE = 2'd2
    } crc_status_t;

    typedef enum logic [1:0] {
        REG_WIDTH      = 2'd0,
        REG_HEIGHT     = 2'd1,
        REG_BACKGROUND = 2'd2
    } crc_reg_t;

    typedef struct packed {
        crc_op_t                    op;
        logic signed [FIELD_W-1:0]  center_x;
        logic signed [FIELD_W-1:0]  center_y;
        logic signed [FIELD_W-1:0]  radius;
        logic [CHAR_W-1:0]          paint_char;
        logic [POS_IN_W-1:0]        read_row;
        logic [POS_IN_W-1:0]        read_col;
    } crc_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [CHAR_W-1:0]  pixel_char;
    } crc_out_t;

    // classified command handed from the front to the back
    typedef struct packed {
        crc_op_t                    op;
        logic signed [FIELD_W-1:0]  center_x;
        logic signed [FIELD_W-1:0]  center_y;
        logic signed [FIELD_W-1:0]  radius;
        logic [CHAR_W-1:0]          paint_char;
        logic [POS_IN_W-1:0]        read_row;
        logic [POS_IN_W-1:0]        read_col;
        logic                       radius_bad;
        logic                       has_inner;
        logic                       outside;
    } crc_cmd_t;

endpackage

`default_nettype wire

### design/crc_front.sv
// Front end: accepts command transactions and classifies them.
`default_nettype none

module crc_front
    import crc_pkg::*;
#(
    parameter int MAX_SIDE  = MAX_SIDE_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [SIDE_W-1:0] width,
    input  wire logic [SIDE_W-1:0] height,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire crc_in_t           cmd,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output crc_cmd_t               out_cmd
);

    localparam int CW = (SIDE_W > POS_IN_W) ? SIDE_W : POS_IN_W;
    localparam logic signed [FIELD_W+1:0] ONE_FX = (FIELD_W + 2)'(1) << FRAC_BITS;

    logic     valid_reg;
    crc_cmd_t cmd_reg;
    crc_cmd_t cls;
    logic     accept;

    always_comb
    begin
        cls.op         = cmd.op;
        cls.center_x   = cmd.center_x;
        cls.center_y   = cmd.center_y;
        cls.radius     = cmd.radius;
        cls.paint_char = cmd.paint_char;
        cls.read_row   = cmd.read_row;
        cls.read_col   = cmd.read_col;
        cls.radius_bad = cmd.radius[FIELD_W-1] || (cmd.radius == '0);
        cls.has_inner  = (FIELD_W + 2)'(cmd.radius) >= ONE_FX;
        cls.outside    = (CW'(cmd.read_row) >= CW'(height)) ||
                         (CW'(cmd.read_col) >= CW'(width));
    end

    assign cmd_ready = !valid_reg || out_ready;
    assign accept    = cmd_valid && cmd_ready;
    assign out_valid = valid_reg;
    assign out_cmd   = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cls;
        end
    end

endmodule

`default_nettype wire

### design/crc_queue.sv
// Short command queue between front and back.
`default_nettype none

module crc_queue
    import crc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push_valid,
    output logic          push_ready,
    input  wire crc_cmd_t push_data,
    output logic          pop_valid,
    input  wire logic     pop_ready,
    output crc_cmd_t      pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    crc_cmd_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### design/crc_back.sv
// Back end: sequencer, squaring unit, pixel walker and frame memory.
`default_nettype none

module crc_back
    import crc_pkg::*;
#(
    parameter int MAX_SIDE  = MAX_SIDE_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [SIDE_W-1:0] width,
    input  wire logic [SIDE_W-1:0] height,
    input  wire logic [CHAR_W-1:0] background_char,
    input  wire logic              q_valid,
    output logic                   q_pop,
    input  wire crc_cmd_t          q_data,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output crc_out_t               rsp
);

    localparam int IDX_W     = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int POS_W     = IDX_W + FRAC_BITS;
    localparam int DW        = ((POS_W > FIELD_W - 1) ? POS_W : FIELD_W - 1) + 3;
    localparam int SQW       = 2 * DW;
    localparam int EW        = (IDX_W + 1 > SIDE_W) ? IDX_W + 1 : SIDE_W;
    localparam logic [DW-1:0]  ONE_FX = DW'(1) << FRAC_BITS;
    localparam logic [SQW-1:0] ONE_SQ = SQW'(1) << (2 * FRAC_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_R,
        ST_SQ_IN,
        ST_SQ_Y,
        ST_SQ_X,
        ST_LOAD,
        ST_WALK,
        ST_READ
    } state_t;

    state_t   state_reg;
    logic     rsp_valid_reg;
    crc_out_t rsp_reg;
    logic     corrupt_reg;

    crc_cmd_t                 cmd_reg;
    logic [IDX_W-1:0]         row_reg;
    logic [IDX_W-1:0]         col_reg;
    logic signed [DW-1:0]     dx_reg;
    logic signed [DW-1:0]     dy_reg;
    logic [SQW-1:0]           dx2_reg;
    logic [SQW-1:0]           dy2_reg;
    logic [SQW-1:0]           cx2_reg;
    logic [SQW-1:0]           r2_reg;
    logic [SQW-1:0]           inner2_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [CHAR_W-1:0]        rd_data_reg;
    logic [CHAR_W-1:0]        mem [MEM_DEPTH];

    logic                     pop;
    logic                     col_last;
    logic                     row_last;
    logic [SQW-1:0]           d2;
    logic                     paint;
    logic                     mem_we;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        rd_addr;
    logic [CHAR_W-1:0]        wr_char;
    logic [FIELD_W-1:0]       sq_mag;
    logic signed [DW-1:0]     neg_cx;
    logic signed [DW-1:0]     neg_cy;
    logic [SQW-1:0]           dx2_step;
    logic [SQW-1:0]           dy2_step;

    function automatic logic [FIELD_W-1:0] mag(input logic signed [FIELD_W:0] v);
        return v[FIELD_W] ? FIELD_W'(-v) : FIELD_W'(v);
    endfunction

    function automatic logic [IDX_W-1:0] to_idx(input logic [POS_IN_W-1:0] p);
        logic [IDX_W+POS_IN_W-1:0] wide;
        wide = {{IDX_W{1'b0}}, p};
        return wide[IDX_W-1:0];
    endfunction

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign q_pop     = pop;

    always_comb
    begin
        pop      = (state_reg == ST_IDLE) && q_valid && !rsp_valid_reg;
        col_last = (EW'(col_reg) + EW'(1)) == EW'(width);
        row_last = (EW'(row_reg) + EW'(1)) == EW'(height);
        d2       = dx2_reg + dy2_reg;
        // outline drops points on or inside the inner ring
        paint    = (d2 <= r2_reg) &&
                   !((cmd_reg.op == OP_OUTLINE) && cmd_reg.has_inner && (d2 <= inner2_reg));
        mem_we   = (state_reg == ST_WALK) && ((cmd_reg.op == OP_CLEAR) || paint);
        wr_addr  = {row_reg, col_reg};
        rd_addr  = {to_idx(q_data.read_row), to_idx(q_data.read_col)};
        wr_char  = (cmd_reg.op == OP_CLEAR) ? background_char : cmd_reg.paint_char;
        neg_cx   = -DW'(cmd_reg.center_x);
        neg_cy   = -DW'(cmd_reg.center_y);
        // (d + 2^F)^2 = d^2 + d*2^(F+1) + 2^(2F)
        dx2_step = dx2_reg + (SQW'(dx_reg) << (FRAC_BITS + 1)) + ONE_SQ;
        dy2_step = dy2_reg + (SQW'(dy_reg) << (FRAC_BITS + 1)) + ONE_SQ;
        unique case (state_reg)
            ST_SQ_R:  sq_mag = mag((FIELD_W + 1)'(cmd_reg.radius));
            ST_SQ_IN: sq_mag = mag((FIELD_W + 1)'(cmd_reg.radius) -
                                   (FIELD_W + 1)'(ONE_FX));
            ST_SQ_Y:  sq_mag = mag((FIELD_W + 1)'(cmd_reg.center_y));
            ST_SQ_X:  sq_mag = mag((FIELD_W + 1)'(cmd_reg.center_x));
            default:  sq_mag = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            corrupt_reg   <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        unique case (q_data.op)
                            OP_CLEAR:
                            begin
                                corrupt_reg <= 1'b0;
                                state_reg   <= ST_WALK;
                            end
                            OP_READ:
                            begin
                                if (q_data.outside)
                                begin
                                    rsp_valid_reg <= 1'b1;
                                    rsp_reg       <= '{status: STATUS_OUTSIDE,
                                                       pixel_char: '0};
                                end
                                else
                                begin
                                    state_reg <= ST_READ;
                                end
                            end
                            OP_OUTLINE, OP_FILLED:
                            begin
                                if (corrupt_reg || q_data.radius_bad)
                                begin
                                    corrupt_reg   <= 1'b1;
                                    rsp_valid_reg <= 1'b1;
                                    rsp_reg       <= '{status: STATUS_REFUSED,
                                                       pixel_char: '0};
                                end
                                else
                                begin
                                    state_reg <= ST_SQ_R;
                                end
                            end
                        endcase
                    end
                end
                ST_SQ_R:  state_reg <= ST_SQ_IN;
                ST_SQ_IN: state_reg <= ST_SQ_Y;
                ST_SQ_Y:  state_reg <= ST_SQ_X;
                ST_SQ_X:  state_reg <= ST_LOAD;
                ST_LOAD:  state_reg <= ST_WALK;
                ST_WALK:
                begin
                    if (col_last && row_last)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_reg       <= '{status: STATUS_OK, pixel_char: '0};
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_READ:
                begin
                    rsp_valid_reg <= 1'b1;
                    rsp_reg       <= '{status: STATUS_OK, pixel_char: rd_data_reg};
                    state_reg     <= ST_IDLE;
                end
            endcase
        end
    end

    // walker datapath and squaring unit
    always_ff @(posedge clk)
    begin
        sq_reg <= sq_mag * sq_mag;
        if (pop)
        begin
            cmd_reg <= q_data;
            row_reg <= '0;
            col_reg <= '0;
        end
        unique case (state_reg)
            ST_SQ_IN: r2_reg     <= SQW'(sq_reg);
            ST_SQ_Y:  inner2_reg <= SQW'(sq_reg);
            ST_SQ_X:  dy2_reg    <= SQW'(sq_reg);
            ST_LOAD:
            begin
                cx2_reg <= SQW'(sq_reg);
                dx2_reg <= SQW'(sq_reg);
                dx_reg  <= neg_cx;
                dy_reg  <= neg_cy;
            end
            ST_WALK:
            begin
                if (col_last)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + IDX_W'(1);
                    dx_reg  <= neg_cx;
                    dx2_reg <= cx2_reg;
                    dy_reg  <= dy_reg + ONE_FX;
                    dy2_reg <= dy2_step;
                end
                else
                begin
                    col_reg <= col_reg + IDX_W'(1);
                    dx_reg  <= dx_reg + ONE_FX;
                    dx2_reg <= dx2_step;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_char;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### design/circle_raster_canvas_top.sv
// Circle raster canvas: register port, front classifier, queue and back end.
// Commands run one at a time; a clear or circle visits one canvas pixel per cycle,
// set by the single write port of the frame memory; a command passes the front
// register and queue; the back end pops it when idle with no response pending.
// Reset clears control state and the corrupted flag and loads size 256 by 256
// (limited to MAX_SIDE) and background 32; the frame memory is left as it is.
`default_nettype none

module circle_raster_canvas_top
    import crc_pkg::*;
#(
    parameter int MAX_SIDE  = MAX_SIDE_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  cmd_valid,
    output logic                       cmd_ready,
    input  wire crc_in_t               cmd,
    output logic                       rsp_valid,
    input  wire logic                  rsp_ready,
    output crc_out_t                   rsp
);

    localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
    localparam int CW        = (SIDE_W > 9) ? SIDE_W : 9;
    localparam int SIDE_INIT = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;

    logic [SIDE_W-1:0] width_reg;
    logic [SIDE_W-1:0] height_reg;
    logic [CHAR_W-1:0] background_reg;
    logic              cfg_write;
    crc_reg_t          reg_sel;
    logic              q_push_valid;
    logic              q_push_ready;
    crc_cmd_t          q_push_data;
    logic              q_valid;
    logic              q_pop;
    crc_cmd_t          q_data;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [8:0] v);
        logic [CW-1:0] e;
        e = CW'(v);
        if (e == '0)
        begin
            return SIDE_W'(1);
        end
        else if (e > CW'(MAX_SIDE))
        begin
            return SIDE_W'(MAX_SIDE);
        end
        return SIDE_W'(e);
    endfunction

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = crc_reg_t'(paddr[3:2]);

    always_comb
    begin
        unique case (reg_sel)
            REG_WIDTH:      prdata = APB_DATA_W'(width_reg);
            REG_HEIGHT:     prdata = APB_DATA_W'(height_reg);
            REG_BACKGROUND: prdata = APB_DATA_W'(background_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= SIDE_W'(SIDE_INIT);
            height_reg     <= SIDE_W'(SIDE_INIT);
            background_reg <= BG_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_WIDTH:      width_reg      <= clamp_side(pwdata[8:0]);
                REG_HEIGHT:     height_reg     <= clamp_side(pwdata[8:0]);
                REG_BACKGROUND: background_reg <= pwdata[CHAR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    crc_front #(
        .MAX_SIDE  (MAX_SIDE),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .width     (width_reg),
        .height    (height_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_valid (q_push_valid),
        .out_ready (q_push_ready),
        .out_cmd   (q_push_data)
    );

    crc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_data   (q_data)
    );

    crc_back #(
        .MAX_SIDE  (MAX_SIDE),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .width           (width_reg),
        .height          (height_reg),
        .background_char (background_reg),
        .q_valid         (q_valid),
        .q_pop           (q_pop),
        .q_data          (q_data),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .rsp             (rsp)
    );

endmodule

`default_nettype wire
